>>> rtl/core/hkpq_pkg.sv
// Shared types and constants for the hour-keyed priority queue.
// Holds the operation and status codes, the entry layout and the control interface.
// No dependencies.
package hkpq_pkg;

	localparam int HOUR_W    = 5;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;
	localparam int DEPTH_DEF = 16;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TAKE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EXISTS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUCC   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PRED   = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// one stored entry: departure hour is the sort key
	typedef struct packed {
		logic [HOUR_W-1:0] dep;
		logic [HOUR_W-1:0] arr;
	} entry_t;

	// controller to datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_START,
		CMD_READ,
		CMD_EVAL,
		CMD_PUT,
		CMD_NB_READ,
		CMD_NB_EVAL,
		CMD_PUBLISH
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic start_done;
		logic start_put;
		logic eval_done;
		logic eval_nb;
		logic eval_put;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/core/hkpq_ctrl.sv
// Sequencing state machine for the hour-keyed priority queue.
// Issues one command per cycle to hkpq_dp and owns the input stall.
// Depends on hkpq_pkg.
module hkpq_ctrl import hkpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output cmd_t     cmd,
	output logic     in_stall
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_READ,
		S_EVAL,
		S_PUT,
		S_NB_READ,
		S_NB_EVAL,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	// state and stall register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_START;
						in_stall_q <= 1'b1;
					end
				end
				S_START: begin
					if (stat.start_done) begin
						state_q <= S_OUT;
					end else if (stat.start_put) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stat.eval_done) begin
						state_q <= S_OUT;
					end else if (stat.eval_nb) begin
						state_q <= S_NB_READ;
					end else if (stat.eval_put) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_PUT: begin
					state_q <= S_OUT;
				end
				S_NB_READ: begin
					state_q <= S_NB_EVAL;
				end
				S_NB_EVAL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			S_IDLE:    cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_START:   cmd = CMD_START;
			S_READ:    cmd = CMD_READ;
			S_EVAL:    cmd = CMD_EVAL;
			S_PUT:     cmd = CMD_PUT;
			S_NB_READ: cmd = CMD_NB_READ;
			S_NB_EVAL: cmd = CMD_NB_EVAL;
			S_OUT:     cmd = stat.out_free ? CMD_PUBLISH : CMD_NONE;
			default:   cmd = CMD_NONE;
		endcase
	end

	assign in_stall = in_stall_q;

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall_q == (state_q != S_IDLE))
		else $error("input stall out of step with controller state");

endmodule

>>> rtl/core/hkpq_dp.sv
// Datapath of the hour-keyed priority queue: sorted entry memory, scan pointers,
// entry count, result registers and the output register.
// Depends on hkpq_pkg; driven by commands from hkpq_ctrl.
module hkpq_dp import hkpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output dp_stat_t            stat,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HOUR_W-1:0]   in_departure,
	input  logic [HOUR_W-1:0]   in_arrival,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [HOUR_W-1:0]   out_departure,
	output logic [HOUR_W-1:0]   out_arrival,
	output logic                hit,
	output logic [STATUS_W-1:0] status,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] ZERO_C  = '0;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;
	entry_t key_q;
	entry_t ret_q;
	logic [KIND_W-1:0]   kind_q;
	logic                hit_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       wptr_q;

	logic                out_valid_q;
	entry_t              out_entry_q;
	logic                out_hit_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic is_insert, is_take, is_delete, is_exists, is_succ, is_scan, kind_ok;
	logic empty, full, match, bigger, last;
	logic [CW-1:0] ptr_inc, ptr_dec, rd_idx, nb_idx;
	logic          wr_en;
	logic [CW-1:0] wr_idx;
	entry_t        wr_data;

	// operation decode and compares
	always_comb begin
		is_insert = kind_q == KIND_INSERT;
		is_take   = kind_q == KIND_TAKE;
		is_delete = kind_q == KIND_DELETE;
		is_exists = kind_q == KIND_EXISTS;
		is_succ   = kind_q == KIND_SUCC;
		is_scan   = is_exists || is_succ || (kind_q == KIND_PRED);
		kind_ok   = kind_q <= KIND_PRED;
		empty     = count_q == ZERO_C;
		full      = count_q == DEPTH_C;
		match     = rd_data_q == key_q;
		bigger    = rd_data_q.dep > key_q.dep;
		ptr_inc   = ptr_q + ONE_C;
		ptr_dec   = ptr_q - ONE_C;
		last      = ptr_inc == count_q;
		// insert walks down from the tail, everything else walks up from the head
		rd_idx    = is_insert ? ptr_dec : ptr_q;
		if (is_succ) begin
			nb_idx = (ptr_inc >= count_q) ? ZERO_C : ptr_inc;
		end else begin
			nb_idx = (ptr_q == ZERO_C) ? (count_q - ONE_C) : ptr_dec;
		end
	end

	// status back to the controller
	always_comb begin
		stat.start_done = !kind_ok || (is_insert ? full : empty);
		stat.start_put  = is_insert && !full && empty;
		stat.eval_done  = ((is_take || is_delete) && last)
			|| (is_scan && (match ? is_exists : last));
		stat.eval_nb    = is_scan && match && !is_exists;
		stat.eval_put   = is_insert && (!bigger || ptr_q == ONE_C);
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// memory write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = ptr_q;
		wr_data = rd_data_q;
		if (cmd == CMD_EVAL) begin
			if (is_insert && bigger) begin
				wr_en = 1'b1;
			end else if (is_take && ptr_q != ZERO_C) begin
				wr_en  = 1'b1;
				wr_idx = ptr_dec;
			end else if (is_delete && !match) begin
				wr_en  = 1'b1;
				wr_idx = wptr_q;
			end
		end else if (cmd == CMD_PUT) begin
			wr_en   = 1'b1;
			wr_data = key_q;
		end
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx[IW-1:0]] <= wr_data;
		end
		if (cmd == CMD_READ || cmd == CMD_NB_READ) begin
			rd_data_q <= mem_q[rd_idx[IW-1:0]];
		end
	end

	// operand, pointer and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				kind_q   <= kind;
				key_q    <= {in_departure, in_arrival};
				hit_q    <= 1'b0;
				status_q <= ST_OK;
				ret_q    <= '0;
				ptr_q    <= (kind == KIND_INSERT) ? count_q : ZERO_C;
				wptr_q   <= ZERO_C;
			end
			CMD_START: begin
				if (kind_ok && is_insert && full) begin
					status_q <= ST_FULL;
				end else if (kind_ok && !is_insert && empty) begin
					status_q <= ST_EMPTY;
				end
			end
			CMD_EVAL: begin
				if (is_insert) begin
					if (bigger) begin
						ptr_q <= ptr_dec;
					end
				end else if (is_take) begin
					if (ptr_q == ZERO_C) begin
						ret_q <= rd_data_q;
						hit_q <= 1'b1;
					end
					ptr_q <= ptr_inc;
				end else if (is_delete) begin
					if (match) begin
						hit_q <= 1'b1;
					end else begin
						wptr_q <= wptr_q + ONE_C;
					end
					ptr_q <= ptr_inc;
				end else begin
					if (match) begin
						hit_q <= 1'b1;
						ptr_q <= nb_idx;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
			end
			CMD_NB_EVAL: begin
				ret_q <= rd_data_q;
			end
			CMD_PUBLISH: begin
				out_entry_q  <= ret_q;
				out_hit_q    <= hit_q;
				out_status_q <= status_q;
				out_occ_q    <= OCC_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ZERO_C;
		end else if (cmd == CMD_PUT) begin
			count_q <= count_q + ONE_C;
		end else if (cmd == CMD_EVAL && last) begin
			if (is_take) begin
				count_q <= count_q - ONE_C;
			end else if (is_delete) begin
				count_q <= wptr_q + CW'(!match);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_departure = out_entry_q.dep;
	assign out_arrival   = out_entry_q.arr;
	assign hit           = out_hit_q;
	assign status        = out_status_q;
	assign occupancy     = out_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond depth");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_PUT |=> count_q == $past(count_q) + ONE_C)
		else $error("insert did not add one entry");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_FULL |-> out_occ_q == OCC_W'(DEPTH_C))
		else $error("full status with queue not full");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> out_status_q == ST_OK)
		else $error("hit reported with error status");

endmodule

>>> rtl/core/hour_keyed_priority_queue.sv
// Hour-keyed priority queue: up to DEPTH entries (departure, arrival) kept in ascending
// departure order, equal departures in arrival-of-request order, in a single-port memory
// with registered read. The memory is scanned one entry at a time, each by a read step and
// an evaluate step. An unused kind, an empty-queue request or a full insert scans nothing;
// take front and delete scan all N entries held; exists scans up to the first matching
// entry (all N on a miss); successor and predecessor add a neighbour read on a hit; insert
// scans entries from the tail until its place is found. One operation is in flight at a
// time; a finished result sits in the output register while the next request is taken.
// No clearing pass after reset.
module hour_keyed_priority_queue import hkpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HOUR_W-1:0]   in_departure,
	input  logic [HOUR_W-1:0]   in_arrival,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HOUR_W-1:0]   out_departure,
	output logic [HOUR_W-1:0]   out_arrival,
	output logic                hit,
	output logic [STATUS_W-1:0] status,
	output logic [OCC_W-1:0]    occupancy
);

	cmd_t     cmd;
	dp_stat_t stat;

	// sequencer
	hkpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// storage and result path
	hkpq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.in_departure  (in_departure),
		.in_arrival    (in_arrival),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_departure (out_departure),
		.out_arrival   (out_arrival),
		.hit           (hit),
		.status        (status),
		.occupancy     (occupancy)
	);

endmodule

>>> dv/hkpq_schedule_checker.sv
// Checker for the hour-keyed priority queue: watches both transfer channels and predicts results.
// Keeps its own sorted copy of the schedule and compares each result transfer field by field.
// Depends on hkpq_pkg.
`timescale 1ns / 100ps

module hkpq_schedule_checker import hkpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HOUR_W-1:0]   in_departure,
	input  logic [HOUR_W-1:0]   in_arrival,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [HOUR_W-1:0]   out_departure,
	input  logic [HOUR_W-1:0]   out_arrival,
	input  logic                hit,
	input  logic [STATUS_W-1:0] status,
	input  logic [OCC_W-1:0]    occupancy,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct packed {
		logic [HOUR_W-1:0]   dep;
		logic [HOUR_W-1:0]   arr;
		logic                hit;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occ;
	} sched_result_t;

	// predicted schedule, ascending departure, ties in insertion order
	entry_t        sched [DEPTH];
	int            held;
	sched_result_t due_q [$];
	sched_result_t want;

	// first position holding exactly this entry, DEPTH on a miss
	function automatic int locate(input entry_t key);
		for (int i = 0; i < held; i++)
			if (sched[i] == key)
				return i;
		return DEPTH;
	endfunction

	// apply one operation to the predicted schedule and return its result
	function automatic sched_result_t schedule_step(input logic [KIND_W-1:0] op,
			input logic [HOUR_W-1:0] dep, input logic [HOUR_W-1:0] arr);
		entry_t        key;
		entry_t        ret;
		sched_result_t r;
		int            pos;
		int            j;
		key.dep = dep;
		key.arr = arr;
		ret     = '0;
		r       = '0;
		pos     = 0;
		j       = 0;
		if (op >= KIND_TAKE && op <= KIND_PRED && held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			case (op)
				KIND_INSERT: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// goes behind every entry with an equal or earlier departure
						while (pos < held && sched[pos].dep <= dep)
							pos++;
						for (int i = held; i > pos; i--)
							sched[i] = sched[i-1];
						sched[pos] = key;
						held++;
					end
				end
				KIND_TAKE: begin
					ret   = sched[0];
					r.hit = 1'b1;
					for (int i = 1; i < held; i++)
						sched[i-1] = sched[i];
					held--;
				end
				KIND_EXISTS: begin
					r.hit = (locate(key) < DEPTH);
				end
				KIND_DELETE: begin
					// compact, dropping every exact match
					for (int i = 0; i < held; i++) begin
						if (sched[i] == key)
							r.hit = 1'b1;
						else
							sched[j++] = sched[i];
					end
					held = j;
				end
				KIND_SUCC, KIND_PRED: begin
					pos = locate(key);
					if (pos < DEPTH) begin
						r.hit = 1'b1;
						// neighbours wrap round at both ends
						if (op == KIND_SUCC)
							ret = sched[(pos + 1 >= held) ? 0 : pos + 1];
						else
							ret = sched[(pos == 0) ? held - 1 : pos - 1];
					end
				end
				default: ;
			endcase
		end
		r.dep = ret.dep;
		r.arr = ret.arr;
		r.occ = OCC_W'(held);
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			fail_count++;
		end
	endtask

	// results are checked before the same edge's request is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held       = 0;
			fail_count = 0;
			due_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$error("result transfer with nothing expected: dep %0d arr %0d",
						out_departure, out_arrival);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					flag_field("out_departure", 8'(want.dep), 8'(out_departure));
					flag_field("out_arrival", 8'(want.arr), 8'(out_arrival));
					flag_field("hit", 8'(want.hit), 8'(hit));
					flag_field("status", 8'(want.status), 8'(status));
					flag_field("occupancy", 8'(want.occ), 8'(occupancy));
				end
			end
			if (in_valid && !in_stall)
				due_q.push_back(schedule_step(kind, in_departure, in_arrival));
			outstanding <= due_q.size();
		end
	end

endmodule

>>> dv/tb_hour_keyed_priority_queue.sv
// Testbench top for the hour-keyed priority queue: clock, reset, request stimulus and verdict.
// Instantiates the block and hkpq_schedule_checker; depends on hkpq_pkg.
`timescale 1ns / 100ps

module tb_hour_keyed_priority_queue;
	import hkpq_pkg::*;

	localparam int ITEMS       = 1800;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 100;

	// kinds the block leaves unused
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [HOUR_W-1:0]   in_departure;
	logic [HOUR_W-1:0]   in_arrival;
	logic                out_valid;
	logic                out_stall;
	logic [HOUR_W-1:0]   out_departure;
	logic [HOUR_W-1:0]   out_arrival;
	logic                hit;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;
	int                  fail_count;
	int                  outstanding;

	int     accepted;
	bit     calm;
	bit     held_off;
	entry_t recent [16];
	int     recent_n;

	hour_keyed_priority_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.in_departure (in_departure),
		.in_arrival   (in_arrival),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_departure(out_departure),
		.out_arrival  (out_arrival),
		.hit          (hit),
		.status       (status),
		.occupancy    (occupancy)
	);

	hkpq_schedule_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.in_departure (in_departure),
		.in_arrival   (in_arrival),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_departure(out_departure),
		.out_arrival  (out_arrival),
		.hit          (hit),
		.status       (status),
		.occupancy    (occupancy),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// result side: random stall, one long hold-off once traffic is flowing
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && accepted >= 40) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 9);
		end
	end

	// hours skewed small so ties and repeats are common; all five bits still toggle
	function automatic logic [HOUR_W-1:0] rand_hour();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return HOUR_W'($urandom_range(0, 7));
		if (roll < 85)
			return HOUR_W'($urandom_range(0, 24));
		return HOUR_W'($urandom_range(0, 31));
	endfunction

	// mostly an entry inserted lately, so lookups tend to hit
	function automatic entry_t known_key();
		entry_t key;
		if (recent_n > 0 && $urandom_range(0, 99) < 75) begin
			key = recent[$urandom_range(0, ((recent_n < 16) ? recent_n : 16) - 1)];
		end else begin
			key.dep = rand_hour();
			key.arr = rand_hour();
		end
		return key;
	endfunction

	// one request transfer, with random idle cycles ahead of it
	task automatic offer(input logic [KIND_W-1:0] k, input logic [HOUR_W-1:0] d,
			input logic [HOUR_W-1:0] a);
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		in_departure <= d;
		in_arrival   <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accepted++;
		if (k == KIND_INSERT) begin
			recent[recent_n % 16] = '{dep: d, arr: a};
			recent_n++;
		end
	endtask

	initial begin
		entry_t            key;
		int                fill_pct;
		int                seg_left;
		int                roll;
		logic [KIND_W-1:0] op;
		in_valid     <= 1'b0;
		kind         <= KIND_INSERT;
		in_departure <= '0;
		in_arrival   <= '0;
		calm     = 1'b0;
		held_off = 1'b0;
		accepted = 0;
		recent_n = 0;
		seg_left = 0;
		fill_pct = 50;
		@(posedge arst_n);
		@(posedge clk);

		// empty queue on every lookup kind, then the unused kinds
		offer(KIND_TAKE, 5'd3, 5'd4);
		offer(KIND_EXISTS, 5'd0, 5'd0);
		offer(KIND_DELETE, 5'd31, 5'd31);
		offer(KIND_SUCC, 5'd24, 5'd24);
		offer(KIND_PRED, 5'd1, 5'd2);
		offer(KIND_SPARE_LO, 5'd31, 5'd0);
		offer(KIND_SPARE_HI, 5'd0, 5'd31);
		// single entry: neighbours are the entry itself
		offer(KIND_INSERT, 5'd31, 5'd31);
		offer(KIND_SUCC, 5'd31, 5'd31);
		offer(KIND_PRED, 5'd31, 5'd31);
		// ties and a duplicate
		offer(KIND_INSERT, 5'd0, 5'd0);
		offer(KIND_INSERT, 5'd24, 5'd24);
		offer(KIND_INSERT, 5'd24, 5'd0);
		offer(KIND_INSERT, 5'd24, 5'd24);
		// wrap at both ends, hits and misses
		offer(KIND_SUCC, 5'd31, 5'd31);
		offer(KIND_PRED, 5'd0, 5'd0);
		offer(KIND_EXISTS, 5'd24, 5'd0);
		offer(KIND_EXISTS, 5'd24, 5'd1);
		offer(KIND_SUCC, 5'd5, 5'd5);
		// delete removes both duplicates, then misses
		offer(KIND_DELETE, 5'd24, 5'd24);
		offer(KIND_DELETE, 5'd24, 5'd24);
		// drain through the front and past empty
		offer(KIND_TAKE, 5'd0, 5'd0);
		offer(KIND_TAKE, 5'd0, 5'd0);
		offer(KIND_TAKE, 5'd0, 5'd0);
		offer(KIND_TAKE, 5'd0, 5'd0);

		// pause until every result is back
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);

		// random part in segments that fill, hover or drain the queue
		for (int n = 0; n < ITEMS; n++) begin
			calm = (n >= 900 && n < 1200);
			if (seg_left == 0) begin
				seg_left = $urandom_range(40, 120);
				case ($urandom_range(0, 2))
					0:       fill_pct = 80;
					1:       fill_pct = 50;
					default: fill_pct = 20;
				endcase
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if (roll < fill_pct) begin
				offer(KIND_INSERT, rand_hour(), rand_hour());
			end else if (roll >= 98) begin
				offer($urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO,
					rand_hour(), rand_hour());
			end else begin
				case ($urandom_range(0, 4))
					0:       op = KIND_TAKE;
					1:       op = KIND_EXISTS;
					2:       op = KIND_DELETE;
					3:       op = KIND_SUCC;
					default: op = KIND_PRED;
				endcase
				key = known_key();
				offer(op, key.dep, key.arr);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
